[design/polygon_backface_cull_unit_macros.svh]
`ifndef POLYGON_BACKFACE_CULL_UNIT_MACROS_SVH
`define POLYGON_BACKFACE_CULL_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polygon_backface_cull_unit: check failed");

// Next-cycle implication, disabled while reset is asserted
`define PBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polygon_backface_cull_unit: check failed");

`endif

[design/pbc_pkg.sv]
package pbc_pkg;

    localparam int ACC_WIDTH = 48;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    // Saturating add in the accumulator range
    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        logic signed [ACC_WIDTH:0] sum;
        sum = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
        begin
            return sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        return sum[ACC_WIDTH-1:0];
    endfunction

endpackage

[design/pbc_edge_mul.sv]
module pbc_edge_mul #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [COORD_WIDTH:0]         d_op,
    input  logic signed [COORD_WIDTH:0]         s_op,
    output logic signed [pbc_pkg::ACC_WIDTH-1:0] term
);
    import pbc_pkg::*;

    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int EW = (PW > ACC_WIDTH + 1) ? PW : ACC_WIDTH + 1;

    localparam logic signed [EW-1:0] HI = EW'(ACC_MAX);
    localparam logic signed [EW-1:0] LO = EW'(ACC_MIN);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [EW-1:0] prod_ext;

    assign prod_next = d_op * s_op;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_ext = EW'(prod_reg);

    // Clamp the registered product to the accumulator range
    always_comb
    begin
        if (prod_ext > HI)
        begin
            term = ACC_MAX;
        end
        else if (prod_ext < LO)
        begin
            term = ACC_MIN;
        end
        else
        begin
            term = prod_ext[ACC_WIDTH-1:0];
        end
    end

endmodule

[design/polygon_backface_cull_unit.sv]
// Back-face cull by signed shoelace area over a streamed polygon.
// Vertex channel: vertex_valid/vertex_stall with x_coord, y_coord and
// last_vertex; one transaction per vertex, last_vertex set on the final one.
// Result channel: result_valid/result_stall with cull and winding_sum; one
// transaction per polygon, produced by its last vertex. winding_sum is the
// saturated sum of (x_next - x_cur) * (y_next + y_cur) over all edges,
// closing edge included; cull is set when that sum is strictly positive.
// Throughput: one vertex per cycle while the result side does not stall,
// set by the single accumulator add that each vertex makes in the
// accumulate stage. After the last vertex is accepted, its result passes
// the edge difference, multiply, accumulate and closing add registers.
// Reset empties the pipeline and waits for the first vertex of a polygon.
// When result_stall holds a waiting result, the pipeline freezes; one more
// vertex is taken into a skid register, then vertex_stall rises until the
// result is taken.
module polygon_backface_cull_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vertex_valid,
    output logic                                 vertex_stall,
    input  logic signed [COORD_WIDTH-1:0]        x_coord,
    input  logic signed [COORD_WIDTH-1:0]        y_coord,
    input  logic                                 last_vertex,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic                                 cull,
    output logic signed [pbc_pkg::ACC_WIDTH-1:0] winding_sum
);
    import pbc_pkg::*;

    localparam int CW = COORD_WIDTH;

    // skid stage
    logic                 skid_valid_reg, skid_valid_next;
    logic signed [CW-1:0] skid_x_reg, skid_y_reg;
    logic                 skid_last_reg;

    // polygon state
    logic                 in_polygon_reg, in_polygon_next;
    logic signed [CW-1:0] first_x_reg, first_x_next;
    logic signed [CW-1:0] first_y_reg, first_y_next;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    acc_t                 acc_reg, acc_next;

    // stage 1: edge operands
    logic               st1_valid_reg, st1_last_reg, st1_first_reg;
    logic signed [CW:0] d1_reg, s1_reg, d2_reg, s2_reg;
    logic signed [CW:0] d1_next, s1_next, d2_next, s2_next;

    // stage 2: products
    logic st2_valid_reg, st2_last_reg, st2_first_reg;
    acc_t t1, t2;

    // stage 3: running sum and closing term
    logic st3_valid_reg, st3_valid_next;
    acc_t sum_a_reg, t2_reg;

    // output stage
    logic result_valid_reg, result_valid_next;
    logic cull_reg;
    acc_t winding_sum_reg, winding_sum_next;

    logic                 advance, accept, src_valid, enter;
    logic signed [CW-1:0] src_x, src_y;
    logic                 src_last;

    assign advance = !(result_valid_reg && result_stall);
    assign accept  = vertex_valid && !skid_valid_reg;

    assign src_valid = skid_valid_reg || vertex_valid;
    assign src_x     = skid_valid_reg ? skid_x_reg : x_coord;
    assign src_y     = skid_valid_reg ? skid_y_reg : y_coord;
    assign src_last  = skid_valid_reg ? skid_last_reg : last_vertex;
    assign enter     = advance && src_valid;

    always_comb
    begin
        if (advance)
        begin
            skid_valid_next = 1'b0;
        end
        else
        begin
            skid_valid_next = skid_valid_reg || accept;
        end
    end

    always_comb
    begin
        first_x_next    = in_polygon_reg ? first_x_reg : src_x;
        first_y_next    = in_polygon_reg ? first_y_reg : src_y;
        in_polygon_next = !src_last;
        d1_next = (CW+1)'(src_x) - (CW+1)'(prev_x_reg);
        s1_next = (CW+1)'(src_y) + (CW+1)'(prev_y_reg);
        d2_next = (CW+1)'(first_x_next) - (CW+1)'(src_x);
        s2_next = (CW+1)'(first_y_next) + (CW+1)'(src_y);
    end

    pbc_edge_mul #(.COORD_WIDTH(CW)) u_mul_edge (
        .clk  (clk),
        .en   (advance),
        .d_op (d1_reg),
        .s_op (s1_reg),
        .term (t1)
    );

    pbc_edge_mul #(.COORD_WIDTH(CW)) u_mul_close (
        .clk  (clk),
        .en   (advance),
        .d_op (d2_reg),
        .s_op (s2_reg),
        .term (t2)
    );

    // First vertex of a polygon restarts the sum and adds no edge
    assign acc_next       = st2_first_reg ? '0 : sat_add(acc_reg, t1);
    assign st3_valid_next = st2_valid_reg && st2_last_reg;

    assign winding_sum_next  = sat_add(sum_a_reg, t2_reg);
    assign result_valid_next = advance ? st3_valid_reg : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg   <= 1'b0;
            in_polygon_reg   <= 1'b0;
            first_x_reg      <= '0;
            first_y_reg      <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            acc_reg          <= '0;
            st1_valid_reg    <= 1'b0;
            st2_valid_reg    <= 1'b0;
            st3_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg   <= skid_valid_next;
            result_valid_reg <= result_valid_next;
            if (enter)
            begin
                in_polygon_reg <= in_polygon_next;
                first_x_reg    <= first_x_next;
                first_y_reg    <= first_y_next;
                prev_x_reg     <= src_x;
                prev_y_reg     <= src_y;
            end
            if (advance)
            begin
                st1_valid_reg <= src_valid;
                st2_valid_reg <= st1_valid_reg;
                st3_valid_reg <= st3_valid_next;
                if (st2_valid_reg)
                begin
                    acc_reg <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !advance)
        begin
            skid_x_reg    <= x_coord;
            skid_y_reg    <= y_coord;
            skid_last_reg <= last_vertex;
        end
        if (advance)
        begin
            st1_last_reg    <= src_last;
            st1_first_reg   <= !in_polygon_reg;
            d1_reg          <= d1_next;
            s1_reg          <= s1_next;
            d2_reg          <= d2_next;
            s2_reg          <= s2_next;
            st2_last_reg    <= st1_last_reg;
            st2_first_reg   <= st1_first_reg;
            sum_a_reg       <= acc_next;
            t2_reg          <= t2;
            winding_sum_reg <= winding_sum_next;
            cull_reg        <= !winding_sum_next[ACC_WIDTH-1] && (winding_sum_next != '0);
        end
    end

    assign vertex_stall = skid_valid_reg;
    assign result_valid = result_valid_reg;
    assign cull         = cull_reg;
    assign winding_sum  = winding_sum_reg;

endmodule

[design/pbc_checker.sv]
`include "polygon_backface_cull_unit_macros.svh"

module pbc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 vertex_stall,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic                                 cull,
    input logic signed [pbc_pkg::ACC_WIDTH-1:0] winding_sum
);
    import pbc_pkg::*;

    // Vertex side backs up only behind a stalled result
    `PBC_ASSERT_NOW(a_stall_cause, clk, rst_n, $rose(vertex_stall), $past(result_valid && result_stall))

    // Skid drains as soon as the result side lets go
    `PBC_ASSERT_NEXT(a_skid_drain, clk, rst_n, vertex_stall && !result_stall, !vertex_stall)

    // Cull flag agrees with the sign of the sum
    `PBC_ASSERT_NOW(a_cull_sign, clk, rst_n, result_valid, cull == (!winding_sum[ACC_WIDTH-1] && (winding_sum != '0)))

    // Stalled result holds
    `PBC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(winding_sum) && $stable(cull))

endmodule

bind polygon_backface_cull_unit pbc_checker u_pbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_stall (vertex_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cull         (cull),
    .winding_sum  (winding_sum)
);
